// ===== src/trpt_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and command codes of the recent-position table
// no dependencies

package trpt_pkg;

  localparam int CHAIN_DEPTH   = 64;
  localparam int BUCKET_COUNT  = 65536;
  localparam int POSITION_BITS = 32;

  localparam int KIND_W      = 2;
  localparam int KEY_W       = 8;
  localparam int POS_FIELD_W = 32;

  localparam int BUCKET_W  = $clog2(BUCKET_COUNT);
  localparam int SLOT_W    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int CNT_W     = $clog2(CHAIN_DEPTH + 1);
  localparam int POS_AW    = BUCKET_W + SLOT_W;
  localparam int POS_DEPTH = BUCKET_COUNT * (1 << SLOT_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    op;
    logic [BUCKET_W-1:0]      bucket;
    logic [POSITION_BITS-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] head;
  } meta_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
    logic                     empty;
  } res_t;

endpackage

// ===== src/trpt_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for command and result transactions
// depends on trpt_pkg

interface trpt_in_if import trpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [KEY_W-1:0]       first_byte;
  logic [KEY_W-1:0]       second_byte;
  logic [POS_FIELD_W-1:0] position;

  modport source (output valid, output kind, output first_byte, output second_byte,
                  output position, input ready);
  modport sink (input valid, input kind, input first_byte, input second_byte,
                input position, output ready);
endinterface

interface trpt_out_if import trpt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [POS_FIELD_W-1:0] found_position;
  logic                   is_last;
  logic                   is_empty;

  modport source (output valid, output found_position, output is_last, output is_empty,
                  input ready);
  modport sink (input valid, input found_position, input is_last, input is_empty,
                output ready);
endinterface

// ===== src/trpt_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module trpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/trpt_front.sv =====
`timescale 1ns / 1ps
// front end: takes command transactions, decodes the kind, forms the bucket
// depends on trpt_pkg and trpt_if

module trpt_front import trpt_pkg::*; (
  trpt_in_if.sink   in_ch,
  input  q_stat_t   q_stat,
  input  logic      clearing,
  output q_push_t   q_push
);

  logic accept;

  assign in_ch.ready = !q_stat.full && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_push.cmd.op     = kind_t'(in_ch.kind);
    q_push.cmd.bucket = {in_ch.first_byte, in_ch.second_byte};
    q_push.cmd.pos    = in_ch.position[POSITION_BITS-1:0];
    unique case (in_ch.kind)
      KIND_INSERT, KIND_LOOKUP, KIND_CLEAR: q_push.valid = accept;
      // unused kind code is taken and dropped
      default:                              q_push.valid = 1'b0;
    endcase
  end

endmodule

// ===== src/trpt_queue.sv =====
`timescale 1ns / 1ps
// short command queue between front end and engine
// depends on trpt_pkg

module trpt_queue import trpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;

  assign push            = q_push.valid;
  assign q_stat.full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.nonempty = (cnt_r != '0);
  assign head            = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= q_push.cmd;
    end
  end

endmodule

// ===== src/trpt_back.sv =====
`timescale 1ns / 1ps
// engine: bucket bookkeeping, position store, clearing pass, result buffer
// depends on trpt_pkg, trpt_if and trpt_ram

module trpt_back import trpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      clearing,
  trpt_out_if.source out_ch
);

  localparam int OB_DEPTH = 2;
  localparam int OB_PTR_W = $clog2(OB_DEPTH);
  localparam int OCC_W    = $clog2(OB_DEPTH + 2);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_META, ST_STREAM} state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                empty_r, empty_nxt;
  logic [BUCKET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                infl_r, infl_last_r, infl_empty_r;
  res_t                ob_r [OB_DEPTH];
  logic [OB_PTR_W-1:0] ob_wp_r, ob_rp_r;
  logic [OCC_W-1:0]    ocnt_r, ocnt_nxt;

  meta_t               meta_rd, meta_wd, meta_new;
  logic                meta_we, meta_re;
  logic [BUCKET_W-1:0] meta_waddr;
  logic [SLOT_W-1:0]   new_head;
  logic                pos_we, pos_re;
  logic [POS_AW-1:0]   pos_waddr, pos_raddr;
  logic [POSITION_BITS-1:0] pos_rd;
  logic [OCC_W-1:0]    occ;
  logic                out_pop, issue_ok, issue, issue_last;
  res_t                push_res;

  trpt_ram #(.WIDTH($bits(meta_t)), .DEPTH(BUCKET_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wd),
    .re    (meta_re),
    .raddr (q_head.bucket),
    .rdata (meta_rd)
  );

  trpt_ram #(.WIDTH(POSITION_BITS), .DEPTH(POS_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (cmd_r.pos),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  // bucket bookkeeping
  assign new_head = (meta_rd.head == SLOT_W'(CHAIN_DEPTH - 1)) ? '0 : meta_rd.head + 1'b1;
  always_comb begin
    meta_new.head = new_head;
    meta_new.cnt  = (meta_rd.cnt < CNT_W'(CHAIN_DEPTH)) ? meta_rd.cnt + 1'b1 : meta_rd.cnt;
  end

  assign clearing   = (state_r == ST_CLEAR);
  assign q_pop      = (state_r == ST_IDLE) && q_stat.nonempty;
  assign meta_re    = q_pop;
  assign pos_we     = (state_r == ST_META) && (cmd_r.op == KIND_INSERT);
  assign meta_we    = clearing || pos_we;
  assign meta_waddr = clearing ? clr_cnt_r : cmd_r.bucket;
  assign meta_wd    = clearing ? '0 : meta_new;
  assign pos_waddr  = {cmd_r.bucket, new_head};
  assign pos_raddr  = {cmd_r.bucket, slot_r};

  // result credit: buffered plus in flight never exceeds the buffer depth
  assign out_pop    = out_ch.valid && out_ch.ready;
  assign occ        = ocnt_r + OCC_W'(infl_r);
  assign issue_ok   = (occ - OCC_W'(out_pop)) < OCC_W'(OB_DEPTH);
  assign issue      = (state_r == ST_STREAM) && issue_ok;
  assign issue_last = empty_r || (rem_r == CNT_W'(1));
  assign pos_re     = issue && !empty_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    rem_nxt     = rem_r;
    slot_nxt    = slot_r;
    empty_nxt   = empty_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_stat.nonempty) begin
          cmd_nxt = q_head;
          if (q_head.op == KIND_CLEAR) begin
            state_nxt   = ST_CLEAR;
            clr_cnt_nxt = '0;
          end else begin
            state_nxt = ST_META;
          end
        end
      end
      ST_META: begin
        unique case (cmd_r.op)
          KIND_LOOKUP: begin
            state_nxt = ST_STREAM;
            rem_nxt   = meta_rd.cnt;
            slot_nxt  = meta_rd.head;
            empty_nxt = (meta_rd.cnt == '0);
          end
          KIND_INSERT: state_nxt = ST_IDLE;
          KIND_CLEAR:  state_nxt = ST_IDLE;
          default:     state_nxt = ST_IDLE;
        endcase
      end
      ST_STREAM: begin
        if (issue) begin
          if (issue_last) begin
            state_nxt = ST_IDLE;
          end else begin
            rem_nxt  = rem_r - 1'b1;
            slot_nxt = (slot_r == '0) ? SLOT_W'(CHAIN_DEPTH - 1) : slot_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (infl_r && !out_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (out_pop && !infl_r) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_comb begin
    push_res.pos   = infl_empty_r ? '0 : pos_rd;
    push_res.last  = infl_last_r;
    push_res.empty = infl_empty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      infl_r    <= 1'b0;
      ocnt_r    <= '0;
      ob_wp_r   <= '0;
      ob_rp_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      infl_r    <= issue;
      ocnt_r    <= ocnt_nxt;
      if (infl_r) begin
        ob_wp_r <= (ob_wp_r == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_wp_r + 1'b1;
      end
      if (out_pop) begin
        ob_rp_r <= (ob_rp_r == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    rem_r   <= rem_nxt;
    slot_r  <= slot_nxt;
    empty_r <= empty_nxt;
    if (issue) begin
      infl_last_r  <= issue_last;
      infl_empty_r <= empty_r;
    end
    if (infl_r) begin
      ob_r[ob_wp_r] <= push_res;
    end
  end

  assign out_ch.valid          = (ocnt_r != '0);
  assign out_ch.found_position = POS_FIELD_W'(ob_r[ob_rp_r].pos);
  assign out_ch.is_last        = ob_r[ob_rp_r].last;
  assign out_ch.is_empty       = ob_r[ob_rp_r].empty;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OCC_W'(OB_DEPTH))
    else $error("result buffer overcommitted");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !q_pop)
    else $error("command taken during clearing pass");

  a_last_flight: assert property (@(posedge clk) disable iff (!rst_n)
    issue && issue_last |=> infl_r && infl_last_r)
    else $error("final result of a lookup lost its marker");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_we |-> (new_head < SLOT_W'(CHAIN_DEPTH - 1)) || (new_head == SLOT_W'(CHAIN_DEPTH - 1)))
    else $error("bucket head outside chain");

endmodule

// ===== src/two_byte_recent_position_table.sv =====
`timescale 1ns / 1ps
// Recent-position table for a match finder. The two key bytes select one of 65536 buckets;
// each bucket holds its last CHAIN_DEPTH positions. In the engine an insert is a queue pop
// with bucket read, then a bucket and position write. A lookup pops and reads the bucket the
// same way and then streams its positions newest first at one result per cycle while the
// sink keeps ready high; an empty bucket yields one result with is_empty set. The bucket
// memory has one read port, so the engine runs one command at a time; a two-entry queue lets
// the input side keep taking transactions meanwhile. After reset and on every clear command,
// a clearing pass writes all 65536 bucket entries at one per cycle; no input transaction is
// taken during that pass. An unused kind code is taken and dropped.
// depends on trpt_pkg, trpt_if, trpt_ram, trpt_front, trpt_queue and trpt_back

module two_byte_recent_position_table import trpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trpt_in_if.sink    in_ch,
  trpt_out_if.source out_ch
);

  q_push_t q_push;
  q_stat_t q_stat;
  cmd_t    q_head;
  logic    q_pop;
  logic    clearing;

  trpt_front u_front (
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .clearing (clearing),
    .q_push   (q_push)
  );

  trpt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .q_stat (q_stat)
  );

  trpt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule

// ===== sim/trpt_position_checker.sv =====
`timescale 1ns / 1ps
// checker for the recent-position table: watches command and result channels,
// keeps its own bucket chains and compares each result transaction in order
// depends on trpt_pkg and trpt_if

module trpt_position_checker import trpt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  trpt_in_if   in_ch,
  trpt_out_if  out_ch,
  output int   mismatch_count,
  output int   outstanding_count
);

  bit [SLOT_W-1:0]          newest_slot [BUCKET_COUNT];
  bit [CNT_W-1:0]           chain_fill  [BUCKET_COUNT];
  logic [POSITION_BITS-1:0] slot_position [int];
  res_t                     awaited_results [$];
  res_t                     oldest;
  int                       fault_tally = 0;

  function automatic void file_position(int unsigned bucket, logic [POS_FIELD_W-1:0] pos);
    int unsigned slot;
    slot = (newest_slot[bucket] + 1) % CHAIN_DEPTH;
    slot_position[bucket * CHAIN_DEPTH + slot] = pos[POSITION_BITS-1:0];
    newest_slot[bucket] = slot[SLOT_W-1:0];
    if (chain_fill[bucket] < CHAIN_DEPTH) begin
      chain_fill[bucket] = chain_fill[bucket] + 1'b1;
    end
  endfunction

  function automatic void queue_chain_results(int unsigned bucket);
    res_t        entry;
    int unsigned fill;
    int unsigned slot;
    fill = chain_fill[bucket];
    if (fill == 0) begin
      entry.pos   = '0;
      entry.last  = 1'b1;
      entry.empty = 1'b1;
      awaited_results.push_back(entry);
      return;
    end
    for (int k = 0; k < fill; k++) begin
      slot        = (newest_slot[bucket] + CHAIN_DEPTH - k) % CHAIN_DEPTH;
      entry.pos   = slot_position[bucket * CHAIN_DEPTH + slot];
      entry.last  = (k + 1 == fill);
      entry.empty = 1'b0;
      awaited_results.push_back(entry);
    end
  endfunction

  function automatic void forget_all_chains();
    for (int b = 0; b < BUCKET_COUNT; b++) begin
      newest_slot[b] = '0;
      chain_fill[b]  = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          KIND_INSERT: file_position({in_ch.first_byte, in_ch.second_byte}, in_ch.position);
          KIND_LOOKUP: queue_chain_results({in_ch.first_byte, in_ch.second_byte});
          KIND_CLEAR:  forget_all_chains();
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction: found_position %h is_last %b is_empty %b",
                   $time, out_ch.found_position, out_ch.is_last, out_ch.is_empty);
          fault_tally++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_ch.found_position !== POS_FIELD_W'(oldest.pos)) begin
            $display("%0t: found_position expected %h, got %h",
                     $time, POS_FIELD_W'(oldest.pos), out_ch.found_position);
            fault_tally++;
          end
          if (out_ch.is_last !== oldest.last) begin
            $display("%0t: is_last expected %b, got %b", $time, oldest.last, out_ch.is_last);
            fault_tally++;
          end
          if (out_ch.is_empty !== oldest.empty) begin
            $display("%0t: is_empty expected %b, got %b", $time, oldest.empty, out_ch.is_empty);
            fault_tally++;
          end
        end
      end
    end
    mismatch_count    <= fault_tally;
    outstanding_count <= awaited_results.size();
  end

endmodule

// ===== sim/two_byte_recent_position_table_test.sv =====
`timescale 1ns / 1ps
// testbench top for the recent-position table: drives insert, lookup, clear and unused-kind
// transactions with random gaps and stalls, verdict from the position checker
// depends on trpt_pkg, trpt_if, two_byte_recent_position_table and trpt_position_checker

module two_byte_recent_position_table_test import trpt_pkg::*; ();

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatch_count;
  int   outstanding_count;
  int   sent_items = 0;
  bit   hold_off_go = 1'b0;
  bit   sender_quiet = 1'b0;
  logic [15:0] busy_buckets [6];

  trpt_in_if  in_ch ();
  trpt_out_if out_ch ();

  two_byte_recent_position_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trpt_position_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .mismatch_count    (mismatch_count),
    .outstanding_count (outstanding_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_bucket();
    if ($urandom_range(0, 3) != 0) return busy_buckets[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_command(logic [KIND_W-1:0] kind, logic [15:0] bucket,
                              logic [POS_FIELD_W-1:0] pos);
    int gap;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.first_byte  <= bucket[15:8];
    in_ch.second_byte <= bucket[7:0];
    in_ch.position    <= pos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (kind != KIND_UNUSED) sent_items++;
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off
  initial begin
    int  run_len;
    int  stall_len;
    bit  rx_quiet;
    bit  hold_off_done;
    rx_quiet      = 1'b0;
    hold_off_done = 1'b0;
    out_ch.ready  = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      run_len = $urandom_range(1, 30);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      stall_len = pick_gap(rx_quiet);
      if (stall_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  initial begin
    int               seg_roll;
    int               kind_roll;
    int               clears_left;
    bit               first_burst;
    logic [15:0]      target;
    logic [KIND_W-1:0] kind;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_INSERT;
    in_ch.first_byte  = '0;
    in_ch.second_byte = '0;
    in_ch.position    = '0;
    busy_buckets[0]   = 16'h0000;
    busy_buckets[1]   = 16'hFFFF;
    busy_buckets[2]   = 16'h00FF;
    busy_buckets[3]   = 16'hFF00;
    busy_buckets[4]   = 16'($urandom);
    busy_buckets[5]   = 16'($urandom);
    clears_left       = 3;
    first_burst       = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: corner buckets, extreme positions, empty, ignored kind, clear
    send_command(KIND_LOOKUP, 16'h0000, 32'h0);
    send_command(KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(KIND_INSERT, 16'h0000, 32'h0000_0000);
    send_command(KIND_INSERT, 16'h0000, 32'hFFFF_FFFF);
    send_command(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(KIND_INSERT, 16'hFF00, 32'hA5A5_A5A5);
    send_command(KIND_INSERT, 16'h00FF, 32'h5A5A_5A5A);
    send_command(KIND_LOOKUP, 16'h0000, 32'h0);
    send_command(KIND_LOOKUP, 16'hFFFF, 32'h0);
    send_command(KIND_LOOKUP, 16'hFF00, 32'h0);
    send_command(KIND_LOOKUP, 16'h00FF, 32'h0);
    send_command(KIND_UNUSED, 16'h0000, 32'h1234_5678);
    send_command(KIND_LOOKUP, 16'h0000, 32'h0);
    send_command(KIND_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(KIND_LOOKUP, 16'h0000, 32'h0);
    send_command(KIND_LOOKUP, 16'hFFFF, 32'h0);
    send_command(KIND_INSERT, 16'h0000, 32'h0000_0001);
    send_command(KIND_LOOKUP, 16'h0000, 32'h0);

    while (sent_items < 455) begin
      seg_roll     = $urandom_range(0, 99);
      sender_quiet = ($urandom_range(0, 4) == 0);
      if (first_burst || seg_roll < 8) begin
        // insert 60 to 72 positions into one bucket so the oldest positions can drop out
        target = busy_buckets[$urandom_range(0, 5)];
        repeat ($urandom_range(60, 72)) send_command(KIND_INSERT, target, $urandom);
        if (first_burst) hold_off_go = 1'b1;
        send_command(KIND_LOOKUP, target, $urandom);
        first_burst = 1'b0;
      end else if (seg_roll < 12 && clears_left > 0) begin
        clears_left--;
        send_command(KIND_CLEAR, pick_bucket(), $urandom);
        send_command(KIND_LOOKUP, pick_bucket(), $urandom);
      end else if (seg_roll < 20) begin
        // noise over the whole key space
        repeat ($urandom_range(4, 10)) begin
          kind = KIND_W'($urandom_range(0, 3));
          if (kind == KIND_CLEAR) kind = KIND_UNUSED;
          send_command(kind, 16'($urandom), $urandom);
        end
      end else begin
        repeat ($urandom_range(10, 30)) begin
          kind_roll = $urandom_range(0, 99);
          if (kind_roll < 55) kind = KIND_INSERT;
          else if (kind_roll < 96) kind = KIND_LOOKUP;
          else kind = KIND_UNUSED;
          send_command(kind, pick_bucket(), $urandom);
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (outstanding_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && outstanding_count == 0) begin
      $display("two_byte_recent_position_table: match");
    end else begin
      $display("two_byte_recent_position_table: mismatch");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("two_byte_recent_position_table: mismatch");
    $finish;
  end

endmodule
